/* rtl/plid_pkg.sv */
// Package for the positional list core: sizes, action and status codes, FSM states.
package plid_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 5;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W = 32;
  localparam int OCNT_W = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DUMP   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_DUMP
  } state_t;

endpackage

/* rtl/positional_list_insert_delete_core.sv */
// Positional list core: packed list in a synchronous RAM with insert, delete and dump.
//
// A transaction is taken when start is high and busy is low. Results appear on
// status/data/count/last for exactly one cycle with strobe high; the receiver cannot
// stall them. Entries live in one RAM with one write and one registered read port,
// so shifting moves one entry per cycle during an insert or delete, and a dump gives
// one result per entry. Rejected or trivial transactions (full, empty, bad position,
// unused action) give one result.
module positional_list_insert_delete_core
  import plid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] data,
  output logic [OCNT_W-1:0]        count,
  output logic                     last
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  state_t              state, state_next;
  logic [CNT_W-1:0]    entry_count, entry_count_next;
  logic [CNT_W-1:0]    ptr, ptr_next;
  logic [CNT_W-1:0]    pos, pos_next;
  logic [DATA_W-1:0]   val, val_next;
  logic                pend, pend_next;
  logic                pend_last, pend_last_next;
  logic [ADDR_W-1:0]   pend_addr, pend_addr_next;
  logic                strobe_next;
  logic [1:0]          status_next;
  logic [DATA_W-1:0]   data_next;
  logic [OCNT_W-1:0]   count_next;
  logic                last_next;
  logic [CNT_W-1:0]    ptr_m1, ptr_p1;

  assign busy   = (state != S_IDLE);
  assign ptr_m1 = ptr - 1'b1;
  assign ptr_p1 = ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    ptr_next         = ptr;
    pos_next         = pos;
    val_next         = val;
    pend_next        = pend;
    pend_last_next   = pend_last;
    pend_addr_next   = pend_addr;
    strobe_next      = 1'b0;
    status_next      = status;
    data_next        = '0;
    count_next       = count;
    last_next        = last;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = '0;
    wr_data          = '0;

    unique case (state)
      S_IDLE: begin
        pend_next = 1'b0;
        if (start) begin
          strobe_next = 1'b1;
          last_next   = 1'b1;
          count_next  = OCNT_W'(entry_count);
          status_next = ST_OK;
          case (action)
            ACT_INSERT: begin
              if (entry_count == CNT_W'(DEPTH)) begin
                status_next = ST_FULL;
              end else if (CMP_W'(position) > CMP_W'(entry_count)) begin
                status_next = ST_BADPOS;
              end else begin
                strobe_next = 1'b0;
                pos_next    = CNT_W'(position);
                val_next    = value;
                ptr_next    = entry_count;
                state_next  = S_UP;
              end
            end
            ACT_DELETE: begin
              if (entry_count == '0) begin
                status_next = ST_EMPTY;
              end else if (CMP_W'(position) >= CMP_W'(entry_count)) begin
                status_next = ST_BADPOS;
              end else begin
                strobe_next = 1'b0;
                pos_next    = CNT_W'(position);
                ptr_next    = CNT_W'(position);
                state_next  = S_DOWN;
              end
            end
            ACT_DUMP: begin
              if (entry_count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                strobe_next = 1'b0;
                ptr_next    = '0;
                state_next  = S_DUMP;
              end
            end
            default: begin
              status_next = ST_BADPOS;
            end
          endcase
        end
      end

      S_UP: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr;
          wr_data = rd_data;
        end
        if (ptr != pos) begin
          rd_en          = 1'b1;
          rd_addr        = ptr_m1[ADDR_W-1:0];
          pend_next      = 1'b1;
          pend_addr_next = ptr[ADDR_W-1:0];
          ptr_next       = ptr_m1;
        end else if (!pend) begin
          wr_en            = 1'b1;
          wr_addr          = pos[ADDR_W-1:0];
          wr_data          = val;
          entry_count_next = entry_count + 1'b1;
          strobe_next      = 1'b1;
          status_next      = ST_OK;
          last_next        = 1'b1;
          count_next       = OCNT_W'(entry_count + 1'b1);
          state_next       = S_IDLE;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_DOWN: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr;
          wr_data = rd_data;
        end
        if (ptr_p1 < entry_count) begin
          rd_en          = 1'b1;
          rd_addr        = ptr_p1[ADDR_W-1:0];
          pend_next      = 1'b1;
          pend_addr_next = ptr[ADDR_W-1:0];
          ptr_next       = ptr_p1;
        end else if (!pend) begin
          entry_count_next = entry_count - 1'b1;
          strobe_next      = 1'b1;
          status_next      = ST_OK;
          last_next        = 1'b1;
          count_next       = OCNT_W'(entry_count - 1'b1);
          state_next       = S_IDLE;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_DUMP: begin
        if (pend) begin
          strobe_next = 1'b1;
          status_next = ST_OK;
          data_next   = rd_data;
          last_next   = pend_last;
          count_next  = OCNT_W'(entry_count);
        end
        if (ptr < entry_count) begin
          rd_en          = 1'b1;
          rd_addr        = ptr[ADDR_W-1:0];
          pend_next      = 1'b1;
          pend_last_next = (ptr_p1 == entry_count);
          ptr_next       = ptr_p1;
        end else begin
          pend_next = 1'b0;
          if (pend && pend_last) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      pend        <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      pend        <= pend_next;
      strobe      <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pos       <= pos_next;
    val       <= val_next;
    pend_last <= pend_last_next;
    pend_addr <= pend_addr_next;
    status    <= status_next;
    data      <= data_next;
    count     <= count_next;
    last      <= last_next;
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the positional list core: directed and random traffic.
module testbench
  import plid_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 155;
  localparam int         QUIET_TAIL   = 40;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data;
    logic [OCNT_W-1:0]         count;
    logic                      last;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] entries [DEPTH];
    int unsigned              fill;
    list_result_t             pending [$];
    int unsigned              errors;

    task report_mismatch(string msg);
      if (errors < 30) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_result(status_t st, logic signed [DATA_W-1:0] d, logic l);
      list_result_t r;
      r.status = st;
      r.data   = d;
      r.count  = OCNT_W'(fill);
      r.last   = l;
      pending.push_back(r);
    endfunction

    function void note_transaction(logic [1:0] act, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
      int unsigned i;
      case (act)
        ACT_INSERT: begin
          if (fill >= DEPTH) begin
            push_result(ST_FULL, '0, 1'b1);
          end else if (pos > fill) begin
            push_result(ST_BADPOS, '0, 1'b1);
          end else begin
            for (i = fill; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            fill++;
            push_result(ST_OK, '0, 1'b1);
          end
        end
        ACT_DELETE: begin
          if (fill == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else if (pos >= fill) begin
            push_result(ST_BADPOS, '0, 1'b1);
          end else begin
            for (i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
            fill--;
            push_result(ST_OK, '0, 1'b1);
          end
        end
        ACT_DUMP: begin
          if (fill == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) push_result(ST_OK, entries[i], i + 1 == fill);
          end
        end
        default: begin
          push_result(ST_BADPOS, '0, 1'b1);
        end
      endcase
    endfunction

    task check_result(logic [1:0] st, logic signed [DATA_W-1:0] d,
                      logic [OCNT_W-1:0] c, logic l);
      list_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d data=%0d count=%0d last=%0b",
                                  st, d, c, l));
        return;
      end
      want = pending.pop_front();
      if (st !== want.status || d !== want.data || c !== want.count || l !== want.last)
        report_mismatch($sformatf(
          "got status=%0d data=%0d count=%0d last=%0b, want status=%0d data=%0d count=%0d last=%0b",
          st, d, c, l, want.status, want.data, want.count, want.last));
    endtask
  endclass

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic [1:0]               action   = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value    = '0;
  logic                     busy;
  logic                     strobe;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic [OCNT_W-1:0]        count;
  logic                     last;

  list_scoreboard sb = new();
  int unsigned    list_len = 0;

  positional_list_insert_delete_core uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .position (position),
    .value    (value),
    .strobe   (strobe),
    .status   (status),
    .data     (data),
    .count    (count),
    .last     (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && busy === 1'b0) sb.note_transaction(action, position, value);
      if (strobe === 1'b1) sb.check_result(status, data, count, last);
    end
  end

  task automatic issue_command(logic [1:0] act, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
    action   <= act;
    position <= pos;
    value    <= val;
    start    <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (act == ACT_INSERT && list_len < DEPTH && pos <= list_len) list_len++;
    else if (act == ACT_DELETE && list_len > 0 && pos < list_len) list_len--;
  endtask

  task automatic pause_start(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int                       k;
    int unsigned              r;
    logic [1:0]               act;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    bit                       grow;
    bit                       quiet;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, bad positions, unused action, extremes, full list
    issue_command(ACT_DUMP, '0, '0);
    issue_command(ACT_DELETE, '0, '0);
    issue_command(ACT_INSERT, 5'd1, 32'sd5);
    issue_command(ACT_UNUSED, 5'd31, -32'sd1);
    issue_command(ACT_INSERT, 5'd0, 32'h8000_0000);
    issue_command(ACT_INSERT, 5'd1, 32'h7fff_ffff);
    issue_command(ACT_INSERT, 5'd31, '0);
    issue_command(ACT_DELETE, 5'd2, '0);
    repeat (14) issue_command(ACT_INSERT, POS_W'($urandom_range(list_len)), $urandom);
    issue_command(ACT_INSERT, 5'd31, $urandom);
    issue_command(ACT_DUMP, '0, '0);
    issue_command(ACT_DELETE, 5'd15, '0);
    issue_command(ACT_DELETE, 5'd0, '0);
    wait_drained();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      grow  = ((k / 30) % 2) == 0;
      quiet = (k >= RANDOM_ITEMS - QUIET_TAIL) || (k >= 60 && k < 85);
      r = $urandom_range(99);
      if (r < 4)                     act = ACT_UNUSED;
      else if (r < 16)               act = ACT_DUMP;
      else if (r < (grow ? 75 : 40)) act = ACT_INSERT;
      else                           act = ACT_DELETE;
      if ($urandom_range(9) == 0)  pos = POS_W'($urandom_range(31));
      else if (act == ACT_INSERT)  pos = POS_W'($urandom_range(list_len));
      else if (list_len == 0)      pos = '0;
      else                         pos = POS_W'($urandom_range(list_len - 1));
      case ($urandom_range(15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = '0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase
      issue_command(act, pos, val);
      if (!quiet && $urandom_range(9) < 3) pause_start($urandom_range(3, 1));
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
